// ----- hw/rtl/bdq_pkg.sv -----
`default_nettype none
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int CMD_W         = 3;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 5;
   localparam int OP_W          = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_LIST      = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // per-cell operations
   localparam logic [OP_W-1:0] OP_HOLD   = 3'd0;
   localparam logic [OP_W-1:0] OP_RIGHT  = 3'd1;
   localparam logic [OP_W-1:0] OP_LEFT   = 3'd2;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
   localparam logic [OP_W-1:0] OP_ROTATE = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ----- hw/rtl/bdq_cell.sv -----
`default_nettype none
module bdq_cell
   import bdq_pkg::*;
(
   input  wire                      clock,
   input  cell_ctrl_type            ctrl,
   input  wire                      strict,
   input  wire                      valid_self,
   input  wire                      valid_left,
   input  wire                      is_tail,
   input  wire                      prior_in,
   input  wire signed [DATA_W-1:0]  left_data,
   input  wire signed [DATA_W-1:0]  right_data,
   input  wire signed [DATA_W-1:0]  head_data,
   output logic signed [DATA_W-1:0] data,
   output logic                     hit
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic                     ge;

   // head compares strictly greater, the rest not less
   assign ge  = strict ? (data_ff > ctrl.value) : (data_ff >= ctrl.value);
   assign hit = (valid_self && ge) || (!valid_self && valid_left);

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         OP_RIGHT:  data_in = left_data;
         OP_LEFT:   data_in = right_data;
         OP_INSERT: begin
            if (prior_in) data_in = left_data;
            else if (hit) data_in = ctrl.value;
         end
         OP_ROTATE: data_in = is_tail ? head_data : right_data;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/bounded_deque_with_ordered_insert.sv -----
// bounded deque with ordered insert, one cell per entry
// a command is taken while the block is idle and executed in the next cycle; its
// status beat is registered and shows in the cycle after, and no new command is
// taken before execution ends; list gives one beat per entry from the rotating
// cell chain and keeps the block busy; results cannot be stalled by the receiver
// synchronous reset empties the store at once; entry data is not cleared
`default_nettype none
module bounded_deque_with_ordered_insert
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   output logic                      busy,
   input  wire  [CMD_W-1:0]          req_command,
   input  wire  signed [DATA_W-1:0]  req_value,
   output logic                      rsp_valid,
   output logic signed [DATA_W-1:0]  rsp_data,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [COUNT_W-1:0]        rsp_count,
   output logic                      rsp_is_empty,
   output logic                      rsp_last
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   // controller states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_LIST = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [IW-1:0]            list_idx_ff, list_idx_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                     rsp_is_empty_ff, rsp_is_empty_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_ctrl_type            ctrl;
   logic [OP_W-1:0]          op;

   logic [DEPTH-1:0]         valid;
   logic [DEPTH-1:0]         hit;
   logic [DEPTH:0]           prior;
   logic signed [DATA_W-1:0] cell_data [DEPTH];

   logic                     accept;
   logic                     full;
   logic                     empty;
   logic                     list_end;

   assign accept   = start && !busy;
   assign busy     = state_ff != ST_IDLE;
   assign full     = count_ff == CW'(DEPTH);
   assign empty    = count_ff == '0;
   assign list_end = list_idx_ff == IW'(count_ff - CW'(1));

   assign ctrl.op    = op;
   assign ctrl.value = value_ff;

   // insert point ripples from head towards tail
   assign prior[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_data;
      logic signed [DATA_W-1:0] right_data;
      logic                     valid_left;
      logic                     is_tail;

      assign valid[i] = CW'(i) < count_ff;

      if (i == 0) begin : g_head
         // the new value enters at the head; an empty store takes it there
         assign left_data  = value_ff;
         assign valid_left = 1'b1;
      end else begin : g_body
         assign left_data  = cell_data[i-1];
         assign valid_left = valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign right_data = cell_data[i];
         assign is_tail    = valid[i];
      end else begin : g_mid
         assign right_data = cell_data[i+1];
         assign is_tail    = valid[i] && !valid[i+1];
      end

      assign prior[i+1] = prior[i] | hit[i];

      bdq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .strict     (i == 0),
         .valid_self (valid[i]),
         .valid_left (valid_left),
         .is_tail    (is_tail),
         .prior_in   (prior[i]),
         .left_data  (left_data),
         .right_data (right_data),
         .head_data  (cell_data[0]),
         .data       (cell_data[i]),
         .hit        (hit[i])
      );
   end

   // command latch
   assign cmd_in   = accept ? req_command : cmd_ff;
   assign value_in = accept ? req_value : value_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      list_idx_in   = list_idx_ff;
      op            = OP_HOLD;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = '0;
      rsp_status_in = STATUS_OK;
      rsp_last_in   = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end

         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            case (cmd_ff)
               CMD_PUSH_HEAD, CMD_INSERT: begin
                  if (full) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     op       = (cmd_ff == CMD_PUSH_HEAD) ? OP_RIGHT : OP_INSERT;
                     count_in = count_ff + CW'(1);
                  end
               end
               CMD_POP_HEAD, CMD_POP_TAIL: begin
                  if (empty) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     // pop tail only drops the count
                     op       = (cmd_ff == CMD_POP_HEAD) ? OP_LEFT : OP_HOLD;
                     count_in = count_ff - CW'(1);
                  end
               end
               CMD_PEEK: begin
                  if (empty) rsp_status_in = STATUS_EMPTY;
                  else       rsp_data_in   = cell_data[0];
               end
               CMD_LIST: begin
                  if (empty) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     rsp_valid_in = 1'b0;
                     state_in     = ST_LIST;
                     list_idx_in  = '0;
                  end
               end
               default: begin
                  // unused codes answer ok and change nothing
               end
            endcase
         end

         ST_LIST: begin
            // head goes out while the chain rotates it round to the tail
            rsp_valid_in = 1'b1;
            rsp_data_in  = cell_data[0];
            op           = OP_ROTATE;
            rsp_last_in  = list_end;
            list_idx_in  = list_idx_ff + IW'(1);
            if (list_end) state_in = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_count_in    = COUNT_W'(count_in);
   assign rsp_is_empty_in = count_in == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      value_ff        <= value_in;
      list_idx_ff     <= list_idx_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_is_empty_ff <= rsp_is_empty_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_last     = rsp_last_ff;

endmodule
`default_nettype wire

// ----- tb/deque_mirror_pkg.sv -----
`timescale 1ns / 1ps
package deque_mirror_pkg;
   import bdq_pkg::*;

   localparam int SLOTS = DEPTH_DEFAULT;

   // codes the block must answer with a plain ok and no change
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   typedef struct {
      logic signed [DATA_W-1:0] data;
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
      logic                     last;
   } deque_beat_t;

   class deque_mirror;
      logic signed [DATA_W-1:0] slots [SLOTS];
      int unsigned              fill;
      deque_beat_t              due_beats [$];
      int unsigned              errors;
      int unsigned              commands_seen;
      int unsigned              beats_seen;
      int unsigned              full_drops;
      int unsigned              empty_answers;
      int unsigned              peak_fill;

      function new();
         fill          = 0;
         errors        = 0;
         commands_seen = 0;
         beats_seen    = 0;
         full_drops    = 0;
         empty_answers = 0;
         peak_fill     = 0;
      endfunction

      function void add_beat(logic signed [DATA_W-1:0] data, logic [STATUS_W-1:0] status,
                             logic last);
         deque_beat_t b;
         b.data     = data;
         b.status   = status;
         b.count    = COUNT_W'(fill);
         b.is_empty = (fill == 0);
         b.last     = last;
         due_beats.push_back(b);
         if (status == STATUS_FULL) full_drops++;
         if (status == STATUS_EMPTY) empty_answers++;
      endfunction

      // one accepted command: update the held copy and queue its beats
      function void apply_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
         int pos;
         commands_seen++;
         case (cmd)
            CMD_PUSH_HEAD, CMD_INSERT: begin
               if (fill >= SLOTS) begin
                  add_beat('0, STATUS_FULL, 1'b1);
               end else begin
                  pos = 0;
                  // equal to the head goes after it; walk starts at the second slot
                  if (cmd == CMD_INSERT && fill != 0 && !(slots[0] > value)) begin
                     pos = fill;
                     for (int i = fill - 1; i >= 1; i--)
                        if (slots[i] >= value) pos = i;
                  end
                  for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
                  slots[pos] = value;
                  fill++;
                  if (fill > peak_fill) peak_fill = fill;
                  add_beat('0, STATUS_OK, 1'b1);
               end
            end
            CMD_POP_HEAD, CMD_POP_TAIL: begin
               if (fill == 0) begin
                  add_beat('0, STATUS_EMPTY, 1'b1);
               end else begin
                  if (cmd == CMD_POP_HEAD)
                     for (int i = 0; i < fill - 1; i++) slots[i] = slots[i+1];
                  fill--;
                  add_beat('0, STATUS_OK, 1'b1);
               end
            end
            CMD_PEEK: begin
               if (fill == 0) add_beat('0, STATUS_EMPTY, 1'b1);
               else add_beat(slots[0], STATUS_OK, 1'b1);
            end
            CMD_LIST: begin
               if (fill == 0) add_beat('0, STATUS_EMPTY, 1'b1);
               else
                  for (int i = 0; i < fill; i++)
                     add_beat(slots[i], STATUS_OK, i == fill - 1);
            end
            default: begin
               add_beat('0, STATUS_OK, 1'b1);
            end
         endcase
      endfunction

      function void check_beat(logic signed [DATA_W-1:0] data, logic [STATUS_W-1:0] status,
                               logic [COUNT_W-1:0] count, logic is_empty, logic last);
         deque_beat_t want;
         if (due_beats.size() == 0) begin
            $error("result beat with nothing outstanding: data %0d status %0d", data, status);
            errors++;
            return;
         end
         want = due_beats.pop_front();
         beats_seen++;
         if (data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, data);
            errors++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
         end
         if (count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count);
            errors++;
         end
         if (is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            errors++;
         end
      endfunction

      function int unsigned outstanding();
         return due_beats.size();
      endfunction
   endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import bdq_pkg::*;
   import deque_mirror_pkg::*;

   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   // how a burst of random commands leans: towards full, towards empty, or neither
   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} bias_mode_e;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [CMD_W-1:0]         req_command = CMD_PEEK;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_data;
   logic [STATUS_W-1:0]      rsp_status;
   logic [COUNT_W-1:0]       rsp_count;
   logic                     rsp_is_empty;
   logic                     rsp_last;

   deque_mirror mirror;

   bounded_deque_with_ordered_insert dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_command  (req_command),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty),
      .rsp_last     (rsp_last)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // monitor: values read here are the ones settled before the edge
   always @(posedge clock) begin
      if (!reset) begin
         // a beat on the result ports is taken at this edge, no back-pressure
         if (rsp_valid)
            mirror.check_beat(rsp_data, rsp_status, rsp_count, rsp_is_empty, rsp_last);
         // a command is taken when start meets a free block
         if (start && !busy)
            mirror.apply_command(req_command, req_value);
      end
   end

   // present one command and hold it until the block takes it
   // start stays high on return so back-to-back commands need no extra edge
   task automatic send_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
      start       <= 1'b1;
      req_command <= cmd;
      req_value   <= value;
      do @(posedge clock); while (busy);
   endtask

   // random sender gaps: each cycle idles with the given chance in a hundred
   task automatic sender_gap(int unsigned pct);
      if ($urandom_range(0, 99) < pct) begin
         start       <= 1'b0;
         req_command <= CMD_W'($urandom_range(0, 7));
         req_value   <= DATA_W'($urandom);
         do @(posedge clock); while ($urandom_range(0, 99) < pct);
      end
   endtask

   // sender holds off until every outstanding beat has come back
   // checked at the falling edge so the monitor has already run
   task automatic drain_results();
      start <= 1'b0;
      do @(negedge clock); while (mirror.outstanding() != 0);
      @(posedge clock);
   endtask

   // random traffic in bursts that lean towards full, empty or nothing
   task automatic run_phase(int unsigned items, int unsigned idle_pct);
      bias_mode_e               mode;
      int unsigned              burst_left;
      int unsigned              pick;
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] value;
      burst_left = 0;
      mode       = MODE_MIXED;
      repeat (items) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(10, 40);
            case ($urandom_range(0, 2))
               0:       mode = MODE_FILL;
               1:       mode = MODE_DRAIN;
               default: mode = MODE_MIXED;
            endcase
         end
         burst_left--;
         pick = $urandom_range(0, 99);
         case (mode)
            MODE_FILL: begin
               // mostly growth, with the odd list or peek to look at the order
               if (pick < 55)      cmd = CMD_INSERT;
               else if (pick < 80) cmd = CMD_PUSH_HEAD;
               else if (pick < 88) cmd = CMD_LIST;
               else if (pick < 93) cmd = CMD_PEEK;
               else if (pick < 97) cmd = CMD_POP_HEAD;
               else                cmd = CMD_POP_TAIL;
            end
            MODE_DRAIN: begin
               if (pick < 35)      cmd = CMD_POP_HEAD;
               else if (pick < 70) cmd = CMD_POP_TAIL;
               else if (pick < 82) cmd = CMD_LIST;
               else if (pick < 92) cmd = CMD_PEEK;
               else                cmd = CMD_INSERT;
            end
            default: begin
               if (pick < 4)      cmd = CMD_SPARE_LO;
               else if (pick < 8) cmd = CMD_SPARE_HI;
               else               cmd = CMD_W'($urandom_range(CMD_PUSH_HEAD, CMD_LIST));
            end
         endcase
         // narrow values give plenty of ties against stored entries
         pick = $urandom_range(0, 9);
         if (pick < 5)      value = DATA_W'($urandom);
         else if (pick < 8) value = DATA_W'($urandom_range(0, 8)) - DATA_W'(4);
         else if (pick < 9) value = VALUE_MIN;
         else               value = VALUE_MAX;
         send_command(cmd, value);
         sender_gap(idle_pct);
      end
   endtask

   initial begin
      mirror = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty store: every reader answers empty, spare codes answer ok
      send_command(CMD_PEEK, VALUE_MAX);
      send_command(CMD_POP_HEAD, '0);
      send_command(CMD_POP_TAIL, '0);
      send_command(CMD_LIST, '0);
      send_command(CMD_SPARE_LO, VALUE_MIN);
      sender_gap(30);
      send_command(CMD_SPARE_HI, '1);
      // ordered insert into an empty store, then below the head
      send_command(CMD_INSERT, '0);
      send_command(CMD_INSERT, VALUE_MIN);
      // tie with the head lands behind it
      send_command(CMD_INSERT, VALUE_MIN);
      send_command(CMD_INSERT, VALUE_MAX);
      send_command(CMD_INSERT, 32'sd5);
      send_command(CMD_INSERT, 32'sd5);
      // unsorted head: a later insert below it becomes the new head
      send_command(CMD_PUSH_HEAD, VALUE_MAX);
      send_command(CMD_INSERT, -32'sd1);
      send_command(CMD_INSERT, 32'sd7);
      send_command(CMD_INSERT, 32'shAAAA_AAAA);
      sender_gap(30);
      send_command(CMD_PUSH_HEAD, 32'sh5555_5555);
      send_command(CMD_LIST, '0);
      send_command(CMD_PEEK, '0);
      send_command(CMD_POP_TAIL, '0);
      send_command(CMD_POP_HEAD, '0);
      send_command(CMD_LIST, '0);
      drain_results();

      // sender idles a little, then a lot, then never
      run_phase(113, 11);
      drain_results();
      run_phase(113, 47);
      drain_results();
      run_phase(114, 0);

      // settle, then keep the clock running so any stray beat is still caught
      drain_results();
      repeat (SLOTS + 8) @(posedge clock);

      $display("covered %0d commands and %0d result beats, peak fill %0d of %0d",
               mirror.commands_seen, mirror.beats_seen, mirror.peak_fill, SLOTS);
      $display("full-store drops %0d, empty-store answers %0d",
               mirror.full_drops, mirror.empty_answers);
      if (mirror.errors == 0 && mirror.outstanding() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_cell.sv
hw/rtl/bounded_deque_with_ordered_insert.sv
tb/deque_mirror_pkg.sv
tb/tb_top.sv
